// ===== rtl/starfield_point_updater_unit_defines.svh =====
// Assertion helpers for the checker file.
`ifndef STARFIELD_POINT_UPDATER_UNIT_DEFINES_SVH
`define STARFIELD_POINT_UPDATER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SFPU_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SFPU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfpu_pkg.sv =====
`default_nettype none

package sfpu_pkg;

    localparam int MAX_STARS_DEF     = 64;
    localparam int FRACTION_BITS_DEF = 7;
    localparam int QUEUE_DEPTH       = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STAR_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_SPEED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SPEED      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STAR_COLOR   = 3'd5;

    // register reset values
    localparam logic [6:0]  STAR_COUNT_RST   = 7'd64;
    localparam logic [11:0] WIDTH_LIMIT_RST  = 12'd319;
    localparam logic [11:0] HEIGHT_LIMIT_RST = 12'd239;
    localparam logic [15:0] SPEED_RST        = 16'd0;
    localparam logic [7:0]  STAR_COLOR_RST   = 8'd255;

    // request kinds
    localparam logic OP_PLACE   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // classified request, front to back
    typedef struct packed {
        logic        opcode;
        logic [15:0] camera_x;
        logic [15:0] camera_y;
        logic [15:0] draw_x_offset;
        logic [15:0] draw_y_offset;
        logic [11:0] rnd_a_w;   // random_a & width_limit
        logic [11:0] rnd_a_h;   // random_a & height_limit
        logic [11:0] rnd_b_h;   // random_b & height_limit
        logic        last;
    } sfpu_item_t;

    // settings the back end needs
    typedef struct packed {
        logic [11:0] width_limit;
        logic [11:0] height_limit;
        logic [15:0] x_speed;
        logic [15:0] y_speed;
        logic [7:0]  star_color;
    } sfpu_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/sfpu_ram.sv =====
`default_nettype none

module sfpu_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/sfpu_front.sv =====
`default_nettype none

module sfpu_front #(
    parameter int  MAX_STARS = sfpu_pkg::MAX_STARS_DEF,
    localparam int IDX_W     = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic                    s_tuser,
    input  wire logic [95:0]             s_tdata,
    input  wire logic [6:0]              star_count,
    input  wire logic [11:0]             width_limit,
    input  wire logic [11:0]             height_limit,
    output logic                         push_valid,
    input  wire logic                    push_ready,
    output sfpu_pkg::sfpu_item_t         push_item,
    output logic      [IDX_W-1:0]        push_index
);
    import sfpu_pkg::*;

    localparam int CMP_W = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;

    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;
    logic [CMP_W-1:0] cnt_raw;
    logic [CMP_W-1:0] cnt_eff;
    logic [CMP_W-1:0] idx_inc;
    logic             last;
    logic             accept;

    // zero count acts as one, counts above the table size saturate
    always_comb begin
        cnt_raw = CMP_W'(star_count);
        if (cnt_raw == '0) begin
            cnt_eff = CMP_W'(1);
        end else if (cnt_raw > CMP_W'(MAX_STARS)) begin
            cnt_eff = CMP_W'(MAX_STARS);
        end else begin
            cnt_eff = cnt_raw;
        end
        idx_inc    = CMP_W'(index_reg) + CMP_W'(1);
        last       = (idx_inc >= cnt_eff);
        index_next = last ? '0 : idx_inc[IDX_W-1:0];
    end

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign push_index = index_reg;

    always_comb begin
        push_item.opcode        = s_tuser;
        push_item.camera_x      = s_tdata[15:0];
        push_item.camera_y      = s_tdata[31:16];
        push_item.draw_x_offset = s_tdata[47:32];
        push_item.draw_y_offset = s_tdata[63:48];
        push_item.rnd_a_w       = s_tdata[75:64] & width_limit;
        push_item.rnd_a_h       = s_tdata[75:64] & height_limit;
        push_item.rnd_b_h       = s_tdata[91:80] & height_limit;
        push_item.last          = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= '0;
        end else if (accept) begin
            index_reg <= index_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfpu_queue.sv =====
`default_nettype none

module sfpu_queue #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = sfpu_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic      [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfpu_back.sv =====
`default_nettype none

module sfpu_back #(
    parameter int  MAX_STARS     = sfpu_pkg::MAX_STARS_DEF,
    parameter int  FRACTION_BITS = sfpu_pkg::FRACTION_BITS_DEF,
    localparam int IDX_W         = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire sfpu_pkg::sfpu_item_t pop_item,
    input  wire logic [IDX_W-1:0]     pop_index,
    input  wire sfpu_pkg::sfpu_cfg_t  cfg,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [39:0]          m_tdata,
    output logic                      m_tlast
);
    import sfpu_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    sfpu_item_t       item_reg;
    logic [IDX_W-1:0] index_reg;
    logic [31:0]      pos_x_reg;
    logic [31:0]      pos_y_reg;
    logic [15:0]      sx_reg;
    logic [15:0]      sy_reg;

    logic             m_valid_reg;
    logic [15:0]      point_x_reg;
    logic [15:0]      point_y_reg;
    logic [7:0]       color_reg;
    logic             last_reg;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      wdata_x;
    logic [31:0]      wdata_y;
    logic [31:0]      rdata_x;
    logic [31:0]      rdata_y;

    logic [31:0]      shx;
    logic [31:0]      shy;
    logic [31:0]      cam_x32;
    logic [31:0]      cam_y32;
    logic [31:0]      rx_rand;
    logic [31:0]      ry_rand;
    logic [31:0]      rx_left;
    logic [31:0]      ry_top;
    logic             exit_left;
    logic             exit_right;
    logic             exit_top;
    logic             exit_bottom;
    logic             emit_go;
    logic             place_go;

    function automatic logic [31:0] fix(input logic [31:0] v);
        return v << FRACTION_BITS;
    endfunction

    sfpu_ram #(.WIDTH(32), .DEPTH(MAX_STARS)) u_ram_x (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata_x),
        .raddr (pop_index),
        .rdata (rdata_x)
    );

    sfpu_ram #(.WIDTH(32), .DEPTH(MAX_STARS)) u_ram_y (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata_y),
        .raddr (pop_index),
        .rdata (rdata_y)
    );

    assign pop_ready = (state_reg == ST_IDLE);
    assign place_go  = pop_valid && pop_ready && (pop_item.opcode == OP_PLACE);
    assign emit_go   = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    // integer pixel positions, fraction bits shifted out
    assign shx = 32'($signed(pos_x_reg) >>> FRACTION_BITS);
    assign shy = 32'($signed(pos_y_reg) >>> FRACTION_BITS);

    // exit tests, left first, bottom last
    assign exit_left   = sx_reg[15];
    assign exit_right  = !sx_reg[15] && (sx_reg[14:0] > {3'b000, cfg.width_limit});
    assign exit_top    = sy_reg[15];
    assign exit_bottom = !sy_reg[15] && (sy_reg[14:0] > {3'b000, cfg.height_limit});

    assign cam_x32 = {{16{item_reg.camera_x[15]}}, item_reg.camera_x};
    assign cam_y32 = {{16{item_reg.camera_y[15]}}, item_reg.camera_y};
    assign rx_rand = {20'd0, item_reg.rnd_a_w} + cam_x32;
    assign ry_rand = {20'd0, item_reg.rnd_a_h} + cam_y32;
    assign rx_left = {20'd0, cfg.width_limit} + cam_x32;
    assign ry_top  = {20'd0, cfg.height_limit} + cam_y32;

    always_comb begin
        we      = 1'b0;
        waddr   = index_reg;
        wdata_x = pos_x_reg;
        wdata_y = pos_y_reg;
        if (place_go) begin
            we      = 1'b1;
            waddr   = pop_index;
            wdata_x = fix({20'd0, pop_item.rnd_a_w});
            wdata_y = fix({20'd0, pop_item.rnd_b_h});
        end else if (emit_go) begin
            we = 1'b1;
            if (exit_left) begin
                wdata_x = fix(rx_left);
                wdata_y = fix(ry_rand);
            end else if (exit_right) begin
                wdata_x = fix(cam_x32);
                wdata_y = fix(ry_rand);
            end else if (exit_top) begin
                wdata_x = fix(rx_rand);
                wdata_y = fix(ry_top);
            end else if (exit_bottom) begin
                wdata_x = fix(rx_rand);
                wdata_y = fix(cam_y32);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid && (pop_item.opcode == OP_ADVANCE)) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:  state_next = ST_EVAL;
            ST_EVAL: state_next = ST_EMIT;
            ST_EMIT: begin
                if (emit_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            item_reg  <= pop_item;
            index_reg <= pop_index;
        end
        if (state_reg == ST_ADD) begin
            pos_x_reg <= rdata_x + {{16{cfg.x_speed[15]}}, cfg.x_speed};
            pos_y_reg <= rdata_y + {{16{cfg.y_speed[15]}}, cfg.y_speed};
        end
        if (state_reg == ST_EVAL) begin
            sx_reg <= shx[15:0] - item_reg.camera_x;
            sy_reg <= shy[15:0] - item_reg.camera_y;
        end
        if (emit_go) begin
            point_x_reg <= sx_reg + item_reg.draw_x_offset;
            point_y_reg <= sy_reg + item_reg.draw_y_offset;
            color_reg   <= cfg.star_color;
            last_reg    <= item_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {color_reg, point_y_reg, point_x_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/starfield_point_updater_unit.sv =====
// Advance request: queued, then RAM read, ADD, EVAL, EMIT sets m_tvalid; back end busy.
// Place request: written to the star RAMs as the back end pops it, no result.
// Throughput set by the back end's read, add, screen-map, write-back sequence on the
// star RAMs; a 2-entry queue lets the front keep taking requests meanwhile.
// Synchronous active-low reset: star index 0, registers to defaults, queue and output
// emptied. Star RAM contents are not cleared and hold nothing meaningful until placed.
`default_nettype none

module starfield_point_updater_unit #(
    parameter int MAX_STARS     = sfpu_pkg::MAX_STARS_DEF,
    parameter int FRACTION_BITS = sfpu_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // request stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic                            s_tuser,   // opcode
    // camera_x[15:0], camera_y[31:16], draw_x_offset[47:32], draw_y_offset[63:48],
    // random_a[79:64], random_b[95:80]
    input  wire logic [95:0]                     s_tdata,
    // point stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // point_x[15:0], point_y[31:16], point_color[39:32]
    output logic      [39:0]                     m_tdata,
    output logic                                 m_tlast,   // last_star
    // register write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sfpu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sfpu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sfpu_pkg::*;

    localparam int IDX_W = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;
    localparam int Q_W   = $bits(sfpu_item_t) + IDX_W;

    // configuration registers
    logic [6:0]  star_count_reg;
    logic [11:0] width_limit_reg;
    logic [11:0] height_limit_reg;
    logic [15:0] x_speed_reg;
    logic [15:0] y_speed_reg;
    logic [7:0]  star_color_reg;
    sfpu_cfg_t   cfg;

    // front to queue
    logic             push_valid;
    logic             push_ready;
    sfpu_item_t       push_item;
    logic [IDX_W-1:0] push_index;

    // queue to back
    logic             pop_valid;
    logic             pop_ready;
    logic [Q_W-1:0]   pop_data;
    sfpu_item_t       pop_item;
    logic [IDX_W-1:0] pop_index;

    // Registers are always writable; software must only write them while idle (not enforced here).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            star_count_reg   <= STAR_COUNT_RST;
            width_limit_reg  <= WIDTH_LIMIT_RST;
            height_limit_reg <= HEIGHT_LIMIT_RST;
            x_speed_reg      <= SPEED_RST;
            y_speed_reg      <= SPEED_RST;
            star_color_reg   <= STAR_COLOR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_STAR_COUNT:   star_count_reg   <= cfg_data[6:0];
                REG_WIDTH_LIMIT:  width_limit_reg  <= cfg_data[11:0];
                REG_HEIGHT_LIMIT: height_limit_reg <= cfg_data[11:0];
                REG_X_SPEED:      x_speed_reg      <= cfg_data;
                REG_Y_SPEED:      y_speed_reg      <= cfg_data;
                REG_STAR_COLOR:   star_color_reg   <= cfg_data[7:0];
                default:          ; // unlisted index: ignored
            endcase
        end
    end

    always_comb begin
        cfg.width_limit  = width_limit_reg;
        cfg.height_limit = height_limit_reg;
        cfg.x_speed      = x_speed_reg;
        cfg.y_speed      = y_speed_reg;
        cfg.star_color   = star_color_reg;
    end

    // Front: takes requests, assigns star index and frame-end flag, masks randoms.
    sfpu_front #(.MAX_STARS(MAX_STARS)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .star_count   (star_count_reg),
        .width_limit  (width_limit_reg),
        .height_limit (height_limit_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item),
        .push_index   (push_index)
    );

    // Short queue decoupling front and back.
    sfpu_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_item, push_index}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_item  = pop_data[Q_W-1:IDX_W];
    assign pop_index = pop_data[IDX_W-1:0];

    // Back: star RAM placement and read-modify-write, edge respawn and point output register.
    sfpu_back #(.MAX_STARS(MAX_STARS), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .pop_index (pop_index),
        .cfg       (cfg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/sfpu_checker.sv =====
`default_nettype none
`include "starfield_point_updater_unit_defines.svh"

module sfpu_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            s_tuser,
    input wire logic [95:0]                     s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [39:0]                     m_tdata,
    input wire logic                            m_tlast,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready,
    input wire logic [sfpu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [sfpu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sfpu_pkg::*;

    logic [3:0] pending_reg;
    logic [6:0] count_shadow_reg;
    logic [7:0] color_shadow_reg;
    logic       adv_in;
    logic       pt_out;
    logic       s_seen;

    assign adv_in = s_tvalid && s_tready && (s_tuser == OP_ADVANCE);
    assign pt_out = m_tvalid && m_tready;
    assign s_seen = |s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg      <= '0;
            count_shadow_reg <= STAR_COUNT_RST;
            color_shadow_reg <= STAR_COLOR_RST;
        end else begin
            pending_reg <= pending_reg + {3'd0, adv_in} - {3'd0, pt_out};
            if (cfg_valid && cfg_ready && (cfg_index == REG_STAR_COUNT)) begin
                count_shadow_reg <= cfg_data[6:0];
            end
            if (cfg_valid && cfg_ready && (cfg_index == REG_STAR_COLOR)) begin
                color_shadow_reg <= cfg_data[7:0];
            end
        end
    end

    `SFPU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "point changed while stalled")
    `SFPU_ASSERT_IMPL(a_out_owed, aclk, aresetn, m_tvalid, pending_reg != 4'd0 || s_seen && 1'b0, "point without an advance request")
    `SFPU_ASSERT_IMPL(a_out_color, aclk, aresetn, m_tvalid, m_tdata[39:32] == color_shadow_reg, "point colour differs from register")
    `SFPU_ASSERT_IMPL(a_single_star, aclk, aresetn, m_tvalid && count_shadow_reg <= 7'd1, m_tlast, "single-star frame without last flag")

endmodule

bind starfield_point_updater_unit sfpu_checker u_sfpu_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

`default_nettype wire
